// File: rtl/core/nnd_pkg.sv
// Shared types and constants of the nearest-neighbor downscaler.
package nnd_pkg;

  localparam int CFG_W = 11;
  localparam int IDX_W = 3;

  localparam logic [CFG_W-1:0] MIN_OUT_SIZE   = CFG_W'(16);
  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = CFG_W'(1280);
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = CFG_W'(720);
  localparam logic [CFG_W-1:0] RST_SRC_PITCH  = CFG_W'(1280);
  localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = CFG_W'(854);
  localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = CFG_W'(480);

  localparam int RED_LSB   = 24;
  localparam int GREEN_LSB = 16;
  localparam int BLUE_LSB  = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_SRC_PITCH  = 3'd2,
    REG_OUT_WIDTH  = 3'd3,
    REG_OUT_HEIGHT = 3'd4
  } reg_idx_e;

  // Effective frame geometry after clamping.
  typedef struct packed {
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] p;
    logic [CFG_W-1:0] ow;
    logic [CFG_W-1:0] oh;
  } geom_t;

  typedef struct packed {
    logic       frame_end;
    logic       row_end;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

endpackage

// File: rtl/core/nearest_neighbor_downscaler_top.sv
// Top level of the nearest-neighbor downscaler: stream ports and pipeline registers.
//
// Nearest-neighbor downscaler. Source RGBA words enter in raster order on the
// slave stream, src_pitch words per row, with tuser high on the first word of
// a frame; words past src_width are padding. Output pixel (x,y) copies source
// pixel (floor(x*W/OW), floor(y*H/OH)), found with column and row step
// accumulators. Each chosen word leaves as 24-bit RGB (alpha dropped), tlast
// on the last pixel of an output row and tuser on the last pixel of the frame.
// Output sizes below 16 or above MAX_OUT_WIDTH/MAX_OUT_HEIGHT fall back to the
// maximum, and are clipped to the source size. Words after the last source row
// produce nothing until the next frame start. Throughput is one word per clock
// while the result slot is free or draining; the scan counters and accumulators
// update once per word, and an input register plus a result register let a new
// word enter while a result still waits. A chosen pixel passes through the input
// register and then the result register before it is offered on the master stream.
// The user must write configuration through cfg_we_i / cfg_index_i / cfg_data_i only
// while the block is idle, unenforced by the block; reset needs no clearing pass.
module nearest_neighbor_downscaler_top import nnd_pkg::*; #(
  parameter int COORD_BITS     = 11,
  parameter int MAX_OUT_WIDTH  = 854,
  parameter int MAX_OUT_HEIGHT = 480
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // source words
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,   // pixel_word
  input  logic             s_axis_tuser_i,   // frame_start
  // output pixels
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // red [7:0], green [15:8], blue [23:16]
  output logic             m_axis_tlast_o,   // row_end
  output logic             m_axis_tuser_o    // frame_end
);

  geom_t       geom;
  logic        in_valid_q;
  logic [31:0] in_word_q;
  logic        in_fs_q;
  logic        step;
  logic        emit;
  pix_t        pix;
  logic        out_valid_q;
  pix_t        out_pix_q;

  // the input register moves on whenever the result slot is free or draining
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  nnd_cfg #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_OUT_HEIGHT(MAX_OUT_HEIGHT)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom)
  );

  nnd_scan #(
    .COORD_BITS(COORD_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .step_i       (step),
    .word_i       (in_word_q),
    .frame_start_i(in_fs_q),
    .emit_o       (emit),
    .pix_o        (pix)
  );

  // input request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_word_q <= s_axis_tdata_i;
      in_fs_q   <= s_axis_tuser_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_pix_q <= pix;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_pix_q.blue, out_pix_q.green, out_pix_q.red};
  assign m_axis_tlast_o  = out_pix_q.row_end;
  assign m_axis_tuser_o  = out_pix_q.frame_end;

endmodule

// File: rtl/core/nnd_cfg.sv
// Configuration registers and effective geometry clamping.
module nnd_cfg import nnd_pkg::*; #(
  parameter int MAX_OUT_WIDTH  = 854,
  parameter int MAX_OUT_HEIGHT = 480
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output geom_t            geom_o
);

  localparam logic [CFG_W-1:0] MaxOw = CFG_W'(MAX_OUT_WIDTH);
  localparam logic [CFG_W-1:0] MaxOh = CFG_W'(MAX_OUT_HEIGHT);

  logic [CFG_W-1:0] src_width_q, src_height_q, src_pitch_q, out_width_q, out_height_q;
  logic [CFG_W-1:0] w, h, p0, ow0, oh0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= RST_SRC_WIDTH;
      src_height_q <= RST_SRC_HEIGHT;
      src_pitch_q  <= RST_SRC_PITCH;
      out_width_q  <= RST_OUT_WIDTH;
      out_height_q <= RST_OUT_HEIGHT;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i;
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i;
        REG_SRC_PITCH:  src_pitch_q  <= cfg_data_i;
        REG_OUT_WIDTH:  out_width_q  <= cfg_data_i;
        REG_OUT_HEIGHT: out_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    // zero sizes count as one
    w  = (src_width_q  == '0) ? CFG_W'(1) : src_width_q;
    h  = (src_height_q == '0) ? CFG_W'(1) : src_height_q;
    p0 = (src_pitch_q  == '0) ? CFG_W'(1) : src_pitch_q;
    // out of range request -> maximum, then no upscaling
    ow0 = (out_width_q < MIN_OUT_SIZE || out_width_q > MaxOw) ? MaxOw : out_width_q;
    oh0 = (out_height_q < MIN_OUT_SIZE || out_height_q > MaxOh) ? MaxOh : out_height_q;
    geom_o.w  = w;
    geom_o.h  = h;
    geom_o.p  = (p0 < w) ? w : p0;
    geom_o.ow = (ow0 > w) ? w : ow0;
    geom_o.oh = (oh0 > h) ? h : oh0;
  end

endmodule

// File: rtl/core/nnd_scan.sv
// Raster position counters, step accumulators and pixel selection.
module nnd_scan import nnd_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  geom_t       geom_i,
  input  logic        step_i,
  input  logic [31:0] word_i,
  input  logic        frame_start_i,
  output logic        emit_o,
  output pix_t        pix_o
);

  localparam int ACC_W = COORD_BITS + 1;
  localparam int CMP_W = (ACC_W > CFG_W + 1) ? ACC_W : CFG_W + 1;

  logic [COORD_BITS-1:0] col_q, row_q, ocol_q, orow_q;
  logic [COORD_BITS-1:0] col_d, row_d, ocol_d, orow_d;
  logic [ACC_W-1:0]      cacc_q, racc_q, cacc_d, racc_d;
  logic                  rsel_q, rsel_d;

  // state seen by this word, after an optional frame restart
  logic [COORD_BITS-1:0] col, row, ocol, orow;
  logic [ACC_W-1:0]      cacc, racc, cacc1, racc1;
  logic                  rsel, active, in_col, take, eol;
  logic [CMP_W-1:0]      ow_x, oh_x;

  always_comb begin
    col  = frame_start_i ? '0 : col_q;
    row  = frame_start_i ? '0 : row_q;
    ocol = frame_start_i ? '0 : ocol_q;
    orow = frame_start_i ? '0 : orow_q;
    cacc = frame_start_i ? '0 : cacc_q;
    racc = frame_start_i ? '0 : racc_q;
    rsel = frame_start_i ? 1'b1 : rsel_q;

    ow_x   = CMP_W'(geom_i.ow);
    oh_x   = CMP_W'(geom_i.oh);
    active = CMP_W'(row) < CMP_W'(geom_i.h);
    in_col = CMP_W'(col) < CMP_W'(geom_i.w);
    take   = in_col && (CMP_W'(cacc) < ow_x);
    eol    = (CMP_W'(col) + CMP_W'(1)) >= CMP_W'(geom_i.p);

    emit_o          = active && take && rsel;
    pix_o.red       = word_i[RED_LSB +: 8];
    pix_o.green     = word_i[GREEN_LSB +: 8];
    pix_o.blue      = word_i[BLUE_LSB +: 8];
    pix_o.row_end   = CMP_W'(ocol) == (ow_x - CMP_W'(1));
    pix_o.frame_end = pix_o.row_end && (CMP_W'(orow) == (oh_x - CMP_W'(1)));

    cacc1 = take ? cacc + ACC_W'(geom_i.w) : cacc;
    racc1 = rsel ? racc + ACC_W'(geom_i.h) : racc;

    col_d  = col;
    row_d  = row;
    ocol_d = ocol;
    orow_d = orow;
    cacc_d = cacc;
    racc_d = racc;
    rsel_d = rsel;
    if (active) begin
      if (take) ocol_d = ocol + COORD_BITS'(1);
      if (in_col) cacc_d = cacc1 - ACC_W'(geom_i.ow);
      if (eol) begin
        col_d  = '0;
        ocol_d = '0;
        cacc_d = '0;
        if (rsel) orow_d = orow + COORD_BITS'(1);
        racc_d = racc1 - ACC_W'(geom_i.oh);
        row_d  = row + COORD_BITS'(1);
        rsel_d = CMP_W'(racc_d) < oh_x;
      end else begin
        col_d = col + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      cacc_q <= '0;
      racc_q <= '0;
      rsel_q <= 1'b1;
    end else if (step_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      cacc_q <= cacc_d;
      racc_q <= racc_d;
      rsel_q <= rsel_d;
    end
  end

endmodule

// File: sim/nearest_neighbor_downscaler_checker.sv
// Checker for the nearest-neighbor downscaler: tracks registers, predicts pixels, compares.
`timescale 1ns / 100ps
module nearest_neighbor_downscaler_checker import nnd_pkg::*; #(
  parameter int MAX_OUT_WIDTH  = 854,
  parameter int MAX_OUT_HEIGHT = 480
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tready_i,
  input  logic [31:0]      s_axis_tdata_i,   // pixel_word
  input  logic             s_axis_tuser_i,   // frame_start
  input  logic             m_axis_tvalid_i,
  input  logic             m_axis_tready_i,
  input  logic [23:0]      m_axis_tdata_i,   // red [7:0], green [15:8], blue [23:16]
  input  logic             m_axis_tlast_i,   // row_end
  input  logic             m_axis_tuser_i,   // frame_end
  output int               errors_o,
  output int               pending_o
);

  typedef logic [CFG_W-1:0] coord_t;
  typedef logic [CFG_W:0]   acc_t;

  coord_t cfg_w, cfg_h, cfg_p, cfg_ow, cfg_oh;
  coord_t src_col, src_row, dst_col, dst_row;
  acc_t   col_acc, row_acc;
  logic   row_taken;
  pix_t   expected_pixels[$];
  int     mismatches;

  function automatic coord_t fit_size(coord_t req, int unsigned max_size, coord_t src);
    coord_t v;
    v = (req < MIN_OUT_SIZE || req > max_size) ? coord_t'(max_size) : req;
    return (v > src) ? src : v;
  endfunction

  task automatic clear_scan();
    src_col   = '0;
    src_row   = '0;
    dst_col   = '0;
    dst_row   = '0;
    col_acc   = '0;
    row_acc   = '0;
    row_taken = 1'b1;
  endtask

  // One source word: advance the scan, queue a pixel when both column and row are taken.
  task automatic scale_word(input logic [31:0] word, input logic first);
    coord_t w, h, p, ow, oh;
    pix_t   px;
    w = (cfg_w == '0) ? coord_t'(1) : cfg_w;
    h = (cfg_h == '0) ? coord_t'(1) : cfg_h;
    p = (cfg_p == '0) ? coord_t'(1) : cfg_p;
    if (p < w) p = w;
    if (first) clear_scan();
    ow = fit_size(cfg_ow, MAX_OUT_WIDTH, w);
    oh = fit_size(cfg_oh, MAX_OUT_HEIGHT, h);
    if (src_row >= h) return;  // frame done, wait for the next start
    if (src_col < w) begin
      if (col_acc < ow) begin
        if (row_taken) begin
          px.red       = word[RED_LSB +: 8];
          px.green     = word[GREEN_LSB +: 8];
          px.blue      = word[BLUE_LSB +: 8];
          px.row_end   = (dst_col == ow - 1'b1);
          px.frame_end = px.row_end && (dst_row == oh - 1'b1);
          expected_pixels.push_back(px);
        end
        dst_col = dst_col + 1'b1;
        col_acc = col_acc + w;
      end
      col_acc = col_acc - ow;
    end
    if ({1'b0, src_col} + 1'b1 >= {1'b0, p}) begin
      src_col = '0;
      dst_col = '0;
      col_acc = '0;
      if (row_taken) begin
        dst_row = dst_row + 1'b1;
        row_acc = row_acc + h;
      end
      row_acc   = row_acc - oh;
      src_row   = src_row + 1'b1;
      row_taken = (row_acc < oh);
    end else begin
      src_col = src_col + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_t got, want;
    if (!rst_ni) begin
      cfg_w  = RST_SRC_WIDTH;
      cfg_h  = RST_SRC_HEIGHT;
      cfg_p  = RST_SRC_PITCH;
      cfg_ow = RST_OUT_WIDTH;
      cfg_oh = RST_OUT_HEIGHT;
      clear_scan();
      expected_pixels.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SRC_WIDTH:  cfg_w  = cfg_data_i;
          REG_SRC_HEIGHT: cfg_h  = cfg_data_i;
          REG_SRC_PITCH:  cfg_p  = cfg_data_i;
          REG_OUT_WIDTH:  cfg_ow = cfg_data_i;
          REG_OUT_HEIGHT: cfg_oh = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) scale_word(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = pix_t'({m_axis_tuser_i, m_axis_tlast_i, m_axis_tdata_i});
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel: expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
            $display("%0t: pixel mismatch: expected r=%h g=%h b=%h row_end=%b frame_end=%b,",
                     $time, want.red, want.green, want.blue, want.row_end, want.frame_end,
                     " got r=%h g=%h b=%h row_end=%b frame_end=%b",
                     got.red, got.green, got.blue, got.row_end, got.frame_end);
            mismatches++;
          end
        end
      end
    end
    pending_o = expected_pixels.size();
    errors_o  = mismatches;
  end

endmodule

// File: sim/nearest_neighbor_downscaler_top_tb.sv
// Testbench top for the nearest-neighbor downscaler: reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module nearest_neighbor_downscaler_top_tb;
  import nnd_pkg::*;

  localparam int COORD_BITS     = 11;
  localparam int MAX_OUT_WIDTH  = 854;
  localparam int MAX_OUT_HEIGHT = 480;
  localparam int RANDOM_WORDS   = 1950;   // counted source words of the random part
  localparam int CYCLE_LIMIT    = 300000; // far above the slowest correct run
  localparam int DRAIN_CYCLES   = 8;      // pixel passes the input and result registers after its word is taken
  localparam int HOLD_CYCLES    = 400;    // long receiver hold-off

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [31:0]      s_axis_tdata_i;   // pixel_word
  logic             s_axis_tuser_i;   // frame_start
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [23:0]      m_axis_tdata_o;   // red [7:0], green [15:8], blue [23:16]
  logic             m_axis_tlast_o;   // row_end
  logic             m_axis_tuser_o;   // frame_end

  int   errors;
  int   pending;
  int   cycle_count  = 0;
  int   random_sent  = 0;
  int   src_idle_pct = 14;
  int   dst_idle_pct = 83;
  logic hold_req     = 1'b0;
  logic hold_done    = 1'b0;

  always #6 clk_i = ~clk_i;

  nearest_neighbor_downscaler_top #(
    .COORD_BITS    (COORD_BITS),
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_OUT_HEIGHT(MAX_OUT_HEIGHT)
  ) u_dut (.*);

  nearest_neighbor_downscaler_checker #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_OUT_HEIGHT(MAX_OUT_HEIGHT)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tlast_i (m_axis_tlast_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count, pending);
      $display("nearest_neighbor_downscaler_top test failed");
      $finish;
    end
  end

  // Receiver: random backpressure, plus one long hold-off when requested so the
  // block's registers fill up and it drops s_axis_tready.
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready_i = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready_i = ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Idling schedule over the random part: slow receiver, then slow sender, then none.
  task automatic pick_idling();
    if (random_sent < RANDOM_WORDS / 3) begin
      src_idle_pct = 14;
      dst_idle_pct = 83;
    end else if (random_sent < 2 * RANDOM_WORDS / 3) begin
      src_idle_pct = 83;
      dst_idle_pct = 14;
    end else begin
      src_idle_pct = 0;
      dst_idle_pct = 0;
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input int value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic program_geometry(input int w, input int h, input int p, input int ow,
                                  input int oh);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_SRC_PITCH, p);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
  endtask

  // Offer one source word; tvalid stays up after the request so back-to-back
  // words need no gap. Returns once the request is taken.
  task automatic send_word(input logic [31:0] word, input logic first);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = word;
    s_axis_tuser_i  = first;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic pause_stream();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // Block idle: every predicted pixel out, then enough cycles for words that
  // make no pixel to clear the pipeline.
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_frame(input int words, input logic restart, input int trailing);
    for (int i = 0; i < words; i++) begin
      pick_idling();
      send_word($urandom(), restart && i == 0);
      random_sent++;
    end
    // words past the last row are dropped by the block
    for (int i = 0; i < trailing; i++) send_word($urandom(), 1'b0);
  endtask

  function automatic int pick_out_size(input int src);
    case ($urandom_range(5))
      0:       return $urandom_range(15);           // below minimum -> maximum
      1:       return $urandom_range(2047);
      default: return $urandom_range(16, (src > 16) ? src : 16);
    endcase
  endfunction

  // Random geometry and one or two frames with random pixels. Mostly complete
  // frames; some cut short, some followed by dropped words, and some phases
  // carry on mid-frame under the new settings.
  task automatic random_phase(input logic first_phase);
    int   w, h, p, ow, oh, w_eff, h_eff, p_eff, words, frames, trailing;
    logic restart;
    case ($urandom_range(9))
      0, 1, 2, 3: begin  // horizontal downscale
        w = $urandom_range(17, 40);
        h = $urandom_range(1, 6);
      end
      4, 5: begin        // vertical downscale
        w = $urandom_range(1, 8);
        h = $urandom_range(17, 24);
      end
      6: begin
        w = $urandom_range(17, 24);
        h = $urandom_range(17, 20);
      end
      7: begin           // zero sizes allowed here
        w = $urandom_range(4);
        h = $urandom_range(4);
      end
      default: begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 8);
      end
    endcase
    w_eff = (w == 0) ? 1 : w;
    h_eff = (h == 0) ? 1 : h;
    case ($urandom_range(7))
      0:       p = 0;
      1:       p = (w_eff > 1) ? $urandom_range(w_eff - 1) : 0;  // pitch below width
      default: p = w_eff + $urandom_range(3);
    endcase
    p_eff = (p == 0) ? 1 : p;
    if (p_eff < w_eff) p_eff = w_eff;
    ow = pick_out_size(w_eff);
    oh = pick_out_size(h_eff);
    program_geometry(w, h, p, ow, oh);
    frames  = $urandom_range(1, 2);
    restart = first_phase || ($urandom_range(4) != 0);
    for (int f = 0; f < frames; f++) begin
      words    = p_eff * h_eff;
      trailing = 0;
      if ($urandom_range(7) == 0) words = $urandom_range(1, words);
      else if ($urandom_range(5) == 0) trailing = $urandom_range(1, 4);
      send_frame(words, restart || f > 0, trailing);
    end
    pause_stream();
    settle();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_SRC_WIDTH;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: 3x2 source, pitch 4; out width below minimum and out height
    // above maximum both fall back to the maximum and then clip to the source.
    program_geometry(3, 2, 4, 0, 2047);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b0);   // padding
    send_word(32'hFF00_00FF, 1'b0);
    send_word(32'h00FF_0000, 1'b0);
    send_word(32'h0000_FF00, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b0);   // padding, frame complete
    send_word(32'hDEAD_BEEF, 1'b0);   // past the last row: dropped
    send_word(32'hCAFE_F00D, 1'b0);
    pause_stream();
    settle();

    // Zero source sizes act as 1x1; each frame start gives one pixel.
    program_geometry(0, 0, 0, 15, 16);
    send_word(32'h8081_8283, 1'b1);
    send_word(32'h7F7E_7D7C, 1'b1);
    pause_stream();
    settle();

    // Pitch below width, out width just above maximum, out height 1.
    program_geometry(5, 2, 2, 855, 1);
    for (int i = 0; i < 5; i++) send_word($urandom(), i == 0);
    pause_stream();
    settle();
    // Shrink the height mid-frame: the scan is now past the last row.
    write_reg(REG_SRC_HEIGHT, 1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    pause_stream();
    settle();

    // Long receiver hold-off on a frame where every word gives a pixel.
    program_geometry(12, 12, 12, 0, 0);
    hold_req = 1'b1;
    send_frame(144, 1'b1, 0);
    pause_stream();
    settle();

    // Largest source: only the start of the frame, default and minimum outputs.
    program_geometry(2047, 2047, 2047, 854, 480);
    send_frame(300, 1'b1, 0);
    pause_stream();
    settle();
    program_geometry(2047, 2047, 2047, 16, 2047);
    send_frame(250, 1'b1, 0);
    pause_stream();
    settle();

    random_phase(1'b1);
    while (random_sent < RANDOM_WORDS) random_phase(1'b0);

    if (errors == 0 && pending == 0) begin
      $display("nearest_neighbor_downscaler_top test passed");
    end else begin
      $display("nearest_neighbor_downscaler_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/nnd_pkg.sv
rtl/core/nnd_cfg.sv
rtl/core/nnd_scan.sv
rtl/core/nearest_neighbor_downscaler_top.sv
sim/nearest_neighbor_downscaler_checker.sv
sim/nearest_neighbor_downscaler_top_tb.sv
